### design/sfc_pkg.sv
package sfc_pkg;

    localparam logic [7:0] START_A     = 8'h42;
    localparam logic [7:0] START_B     = 8'h4d;
    localparam logic [7:0] LEN_MEASURE = 8'd28;
    localparam logic [7:0] LEN_COMMAND = 8'd4;

    localparam int NUM_WORDS = 13;
    localparam logic [3:0] LAST_WORD = 4'(NUM_WORDS - 1);

    // payload bytes per frame: length minus the two checksum bytes
    localparam logic [4:0] PAYLOAD_MEASURE = 5'(LEN_MEASURE - 8'd2);
    localparam logic [4:0] PAYLOAD_COMMAND = 5'(LEN_COMMAND - 8'd2);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] STATUS_MEASURE = 2'd0;
    localparam logic [1:0] STATUS_COMMAND = 2'd1;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd2;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd3;

    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_MEASURE = 3'd1,
        OP_COMMAND = 3'd2,
        OP_BAD_SUM = 3'd3,
        OP_BAD_LEN = 3'd4
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  index;
        logic [15:0] value;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### design/sfc_front.sv
module sfc_front
    import sfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rx_valid,
    output logic          rx_stall,
    input  logic [7:0]    rx_byte,
    input  queue_status_t q_status,
    output logic          push,
    output entry_t        push_entry
);

    typedef enum logic [6:0] {
        PH_HUNT_A   = 7'b0000001,
        PH_HUNT_B   = 7'b0000010,
        PH_SKIP     = 7'b0000100,
        PH_LENGTH   = 7'b0001000,
        PH_PAYLOAD  = 7'b0010000,
        PH_SUM_HIGH = 7'b0100000,
        PH_SUM_LOW  = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic        measure_reg, measure_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  high_reg, high_next;

    logic        accept;
    logic [15:0] sum_add;
    logic [4:0]  pos_inc;
    logic [4:0]  payload_len;

    // each byte pushes at most one entry, so a free slot is enough
    assign rx_stall = q_status.full;
    assign accept   = rx_valid && !rx_stall;

    assign sum_add     = sum_reg + {8'd0, rx_byte};
    assign pos_inc     = pos_reg + 5'd1;
    assign payload_len = measure_reg ? PAYLOAD_MEASURE : PAYLOAD_COMMAND;

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        measure_next = measure_reg;
        sum_next     = sum_reg;
        high_next    = high_reg;
        push         = 1'b0;
        push_entry   = '{op: OP_WRITE, index: 4'd0, value: 16'd0};
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT_A:
                begin
                    if (rx_byte == START_A)
                    begin
                        sum_next   = {8'd0, rx_byte};
                        phase_next = PH_HUNT_B;
                    end
                end
                PH_HUNT_B:
                begin
                    if (rx_byte == START_B)
                    begin
                        sum_next   = sum_add;
                        phase_next = PH_SKIP;
                    end
                    else if (rx_byte == START_A)
                    begin
                        sum_next = {8'd0, rx_byte};
                    end
                    else
                    begin
                        phase_next = PH_HUNT_A;
                    end
                end
                PH_SKIP:
                begin
                    phase_next = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    if (rx_byte != LEN_MEASURE && rx_byte != LEN_COMMAND)
                    begin
                        phase_next    = PH_HUNT_A;
                        push          = 1'b1;
                        push_entry.op = OP_BAD_LEN;
                    end
                    else
                    begin
                        measure_next = (rx_byte == LEN_MEASURE);
                        sum_next     = sum_add;
                        pos_next     = 5'd0;
                        phase_next   = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    sum_next = sum_add;
                    if (!pos_reg[0])
                    begin
                        high_next = rx_byte;
                    end
                    else
                    begin
                        push       = 1'b1;
                        push_entry = '{op: OP_WRITE, index: pos_reg[4:1],
                                       value: {high_reg, rx_byte}};
                    end
                    pos_next = pos_inc;
                    if (pos_inc >= payload_len)
                    begin
                        phase_next = PH_SUM_HIGH;
                    end
                end
                PH_SUM_HIGH:
                begin
                    high_next  = rx_byte;
                    phase_next = PH_SUM_LOW;
                end
                PH_SUM_LOW:
                begin
                    phase_next = PH_HUNT_A;
                    push       = 1'b1;
                    if ({high_reg, rx_byte} != sum_reg)
                    begin
                        push_entry.op = OP_BAD_SUM;
                    end
                    else if (measure_reg)
                    begin
                        push_entry.op = OP_MEASURE;
                    end
                    else
                    begin
                        push_entry.op = OP_COMMAND;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT_A;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT_A;
            pos_reg     <= 5'd0;
            measure_reg <= 1'b0;
            sum_reg     <= 16'd0;
            high_reg    <= 8'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            measure_reg <= measure_next;
            sum_reg     <= sum_next;
            high_reg    <= high_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_frame_end_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_SUM_LOW) |=> phase_reg == PH_HUNT_A)
        else $error("parser did not return to hunting after a frame");
    a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> pos_reg < payload_len)
        else $error("payload position ran past the frame");
`endif

endmodule

### design/sfc_queue.sv
module sfc_queue
    import sfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  entry_t        push_entry,
    input  logic          pop,
    output entry_t        head,
    output queue_status_t q_status
);

    entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign q_status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = slot_reg[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QUEUE_CNT_W'(1);
                2'b01:   count_reg <= count_reg - QUEUE_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("entry pushed into a full queue");
`endif

endmodule

### design/sfc_back.sv
module sfc_back
    import sfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  entry_t        head,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          res_valid,
    input  logic          res_stall,
    output logic [1:0]    status,
    output logic [3:0]    word_index,
    output logic [15:0]   word_value,
    output logic          last
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_SHOW = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    op_t         op_reg, op_next;
    logic [3:0]  idx_reg, idx_next;
    logic [15:0] rd_data_reg;
    logic [15:0] word_mem [NUM_WORDS];

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [3:0]  out_index_reg;
    logic [15:0] out_value_reg;
    logic        out_last_reg;

    logic        out_free;
    logic        load;
    logic [1:0]  cur_status;
    logic        cur_error;
    logic        cur_last;

    assign out_free = !out_valid_reg || !res_stall;
    assign pop      = (state_reg == B_IDLE) && !q_status.empty;
    assign load     = (state_reg == B_SHOW) && out_free;

    always_comb
    begin
        case (op_reg)
            OP_MEASURE: cur_status = STATUS_MEASURE;
            OP_COMMAND: cur_status = STATUS_COMMAND;
            OP_BAD_SUM: cur_status = STATUS_BAD_SUM;
            default:    cur_status = STATUS_BAD_LEN;
        endcase
    end

    assign cur_error = (op_reg == OP_BAD_SUM) || (op_reg == OP_BAD_LEN);
    assign cur_last  = (op_reg != OP_MEASURE) || (idx_reg == LAST_WORD);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop && head.op != OP_WRITE)
                begin
                    op_next  = head.op;
                    idx_next = 4'd0;
                    if (head.op == OP_MEASURE || head.op == OP_COMMAND)
                    begin
                        state_next = B_READ;
                    end
                    else
                    begin
                        state_next = B_SHOW;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_SHOW;
            end
            B_SHOW:
            begin
                if (out_free)
                begin
                    if (cur_last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 4'd1;
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // word writes come through the queue, so they never overtake an emit
    always_ff @(posedge clk)
    begin
        if (pop && head.op == OP_WRITE)
        begin
            word_mem[head.index] <= head.value;
        end
        if (state_reg == B_READ)
        begin
            rd_data_reg <= word_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            op_reg        <= OP_WRITE;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            idx_reg   <= idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= cur_status;
            out_index_reg  <= idx_reg;
            out_value_reg  <= cur_error ? 16'd0 : rd_data_reg;
            out_last_reg   <= cur_last;
        end
    end

    assign res_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign word_index = out_index_reg;
    assign word_value = out_value_reg;
    assign last       = out_last_reg;

`ifndef NO_ASSERTIONS
    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status == STATUS_BAD_SUM || status == STATUS_BAD_LEN))
        |-> (word_value == 16'd0 && word_index == 4'd0 && last))
        else $error("error result carries a word");
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> idx_reg <= LAST_WORD)
        else $error("word index ran past the store");
    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> !pop)
        else $error("queue popped during emission");
`endif

endmodule

### design/sensor_frame_checker_core.sv
// Frame checker for a sensor serial line. Feed one received byte per item on
// rx_*; results come out on res_* with status, word_index, word_value and last.
// A byte is taken while the four-entry queue between the parser and the result
// engine has room; rx_stall rises only when that queue is full. The result
// engine pops one queue entry per cycle while idle, and pops none while it
// emits a frame's results. A good measurement frame yields 13 results, each
// read from the word store and then loaded into the output register, which
// res_stall holds; a command response and an error result yield one result
// each. Results of a frame appear after its last checksum byte, with last set
// on the final one.
module sensor_frame_checker_core
    import sfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic [3:0]  word_index,
    output logic [15:0] word_value,
    output logic        last
);

    queue_status_t q_status;
    logic          push;
    entry_t        push_entry;
    logic          pop;
    entry_t        head;

    sfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    sfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    sfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .status     (status),
        .word_index (word_index),
        .word_value (word_value),
        .last       (last)
    );

endmodule
